// ===== sv/lobm_pkg.sv =====
// Shared types, codes and sizes of the limit order book matcher.
`timescale 1ns / 1ps

package lobm_pkg;

   localparam int MAX_ORDERS_DEF = 32;
   localparam int MAX_LEVELS_DEF = 32;

   localparam logic [2:0] OP_ADD     = 3'd0;
   localparam logic [2:0] OP_CANCEL  = 3'd1;
   localparam logic [2:0] OP_REDUCE  = 3'd2;
   localparam logic [2:0] OP_REPLACE = 3'd3;
   localparam logic [2:0] OP_QUERY   = 3'd4;

   localparam logic [2:0] QK_BID    = 3'd0;
   localparam logic [2:0] QK_OFFER  = 3'd1;
   localparam logic [2:0] QK_VOLUME = 3'd2;
   localparam logic [2:0] QK_DEPTH  = 3'd3;
   localparam logic [2:0] QK_INFO   = 3'd4;

   localparam logic [2:0] RK_EXEC     = 3'd0;
   localparam logic [2:0] RK_BID      = 3'd1;
   localparam logic [2:0] RK_OFFER    = 3'd2;
   localparam logic [2:0] RK_VOLUME   = 3'd3;
   localparam logic [2:0] RK_DEPTH    = 3'd4;
   localparam logic [2:0] RK_INFO     = 3'd5;
   localparam logic [2:0] RK_NOTFOUND = 3'd6;
   localparam logic [2:0] RK_REJECT   = 3'd7;

   typedef struct packed {
      logic [2:0]  operation;
      logic [63:0] order_ref;
      logic [63:0] new_order_id;
      logic        side;
      logic [31:0] quantity;
      logic [31:0] price;
      logic [63:0] account_ref;
      logic [63:0] query_id;
      logic [2:0]  query_kind;
      logic [63:0] query_param;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [63:0] buyer_order_id;
      logic [63:0] seller_order_id;
      logic [31:0] trade_price;
      logic [31:0] trade_quantity;
      logic [63:0] answer_query_id;
      logic [31:0] answer_price;
      logic [31:0] answer_volume;
      logic [5:0]  buy_levels;
      logic [5:0]  sell_levels;
      logic        answer_side;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [63:0] ident;
      logic        side;
      logic [31:0] quantity;
      logic [31:0] price;
      logic [63:0] owner;
      logic [31:0] arrival;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ADD,
      S_SCAN,
      S_EVAL,
      S_FILL,
      S_REMOVE,
      S_REST_WRITE,
      S_PUSH,
      S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      SK_MATCH,
      SK_LOOKUP,
      SK_LEVEL_REM,
      SK_LEVEL_REST,
      SK_VOLUME,
      SK_BEST
   } scan_type;

endpackage

// ===== sv/lobm_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module lobm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/limit_order_book_matcher_unit.sv =====
// Top level: price-time-priority order book with one entry memory and a scan sequencer.
// Every search reads the whole order memory once, one entry a cycle.
// A query takes one scan (depth none); cancel, reduce, replace one or two; a found replace adds.
// An add: one scan per fill, one more per order used up, two more when a remainder is left.
// One item is worked on at a time; a finished result waits in the output register.
// Reset clears valid bits, counters and control; there is no clearing pass.
`timescale 1ns / 1ps

module limit_order_book_matcher_unit #(
   parameter int MAX_ORDERS = lobm_pkg::MAX_ORDERS_DEF,
   parameter int MAX_LEVELS = lobm_pkg::MAX_LEVELS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lobm_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lobm_pkg::rsp_type rsp_payload
);

   localparam int IDXW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(MAX_ORDERS - 1);
   localparam logic [6:0] LEVEL_CAP = 7'(MAX_LEVELS);
   localparam int EW = $bits(lobm_pkg::entry_type);

   lobm_pkg::state_type state_ff, state_in;
   lobm_pkg::req_type   req_ff, req_in;
   logic [63:0] work_id_ff, work_id_in;
   logic        work_side_ff, work_side_in;
   logic [31:0] work_qty_ff, work_qty_in;
   logic [31:0] work_price_ff, work_price_in;
   logic [63:0] work_owner_ff, work_owner_in;
   logic        cont_add_ff, cont_add_in;
   lobm_pkg::scan_type scan_kind_ff, scan_kind_in;
   logic [IDXW-1:0] scan_idx_ff, scan_idx_in;
   logic        issue_done_ff, issue_done_in;
   logic        rd_v_ff, rd_v_in;
   logic [IDXW-1:0] rd_idx_ff, rd_idx_in;
   logic        found_ff, found_in;
   logic [IDXW-1:0] cand_idx_ff, cand_idx_in;
   lobm_pkg::entry_type cand_ff, cand_in;
   logic        free_found_ff, free_found_in;
   logic [IDXW-1:0] free_idx_ff, free_idx_in;
   logic [31:0] vol_ff, vol_in;
   logic [63:0] key_id_ff, key_id_in;
   logic [31:0] key_price_ff, key_price_in;
   logic        key_side_ff, key_side_in;
   lobm_pkg::rsp_type pend_ff, pend_in;
   logic        hold_v_ff, hold_v_in;
   lobm_pkg::rsp_type hold_ff, hold_in;
   logic        rsp_valid_ff, rsp_valid_in;
   lobm_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [MAX_ORDERS-1:0] valid_ff, valid_in;
   logic [31:0] arrival_ff, arrival_in;
   logic [5:0]  buy_tot_ff, buy_tot_in;
   logic [5:0]  sell_tot_ff, sell_tot_in;

   logic        ram_we;
   logic [IDXW-1:0] ram_waddr;
   lobm_pkg::entry_type ram_wdata;
   lobm_pkg::entry_type rd_entry;
   logic [EW-1:0] rd_bits;

   logic        out_free, can_push, scan_last, level_full, rd_vld;
   logic [31:0] age_rd, age_cand, fill_qty;
   logic [32:0] vol_sum;
   logic        push_en, flush_en;
   lobm_pkg::rsp_type push_data;

   lobm_ram #(.WIDTH(EW), .DEPTH(MAX_ORDERS), .AW(IDXW)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_bits)
   );

   assign rd_entry  = lobm_pkg::entry_type'(rd_bits);
   assign req_ready = (state_ff == lobm_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign can_push  = !hold_v_ff || out_free;
   assign scan_last = rd_v_ff && (rd_idx_ff == LAST_IDX);
   assign rd_vld    = rd_v_ff && valid_ff[rd_idx_ff];
   assign age_rd    = arrival_ff - rd_entry.arrival;
   assign age_cand  = arrival_ff - cand_ff.arrival;
   assign vol_sum   = {1'b0, vol_ff} + {1'b0, rd_entry.quantity};
   assign level_full = ({1'b0, buy_tot_ff} + {1'b0, sell_tot_ff}) == LEVEL_CAP;
   assign fill_qty  = (work_qty_ff < cand_ff.quantity) ? work_qty_ff : cand_ff.quantity;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lobm_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = lobm_pkg::S_DECODE;
            end
         end
         lobm_pkg::S_DECODE: begin
            case (req_ff.operation)
               lobm_pkg::OP_ADD: state_in = lobm_pkg::S_ADD;
               lobm_pkg::OP_CANCEL, lobm_pkg::OP_REDUCE,
               lobm_pkg::OP_REPLACE: state_in = lobm_pkg::S_SCAN;
               lobm_pkg::OP_QUERY: begin
                  case (req_ff.query_kind)
                     lobm_pkg::QK_BID, lobm_pkg::QK_OFFER, lobm_pkg::QK_VOLUME,
                     lobm_pkg::QK_INFO: state_in = lobm_pkg::S_SCAN;
                     lobm_pkg::QK_DEPTH: state_in = lobm_pkg::S_PUSH;
                     default: state_in = lobm_pkg::S_FINISH;
                  endcase
               end
               default: state_in = lobm_pkg::S_FINISH;
            endcase
         end
         lobm_pkg::S_ADD: begin
            state_in = (work_qty_ff == '0) ? lobm_pkg::S_FINISH : lobm_pkg::S_SCAN;
         end
         lobm_pkg::S_SCAN: begin
            if (scan_last) begin
               state_in = lobm_pkg::S_EVAL;
            end
         end
         lobm_pkg::S_EVAL: begin
            case (scan_kind_ff)
               lobm_pkg::SK_MATCH: begin
                  state_in = found_ff ? lobm_pkg::S_FILL : lobm_pkg::S_SCAN;
               end
               lobm_pkg::SK_LOOKUP: begin
                  if (req_ff.operation == lobm_pkg::OP_QUERY) begin
                     state_in = lobm_pkg::S_PUSH;
                  end else if (!found_ff) begin
                     state_in = lobm_pkg::S_FINISH;
                  end else if (req_ff.operation == lobm_pkg::OP_REDUCE &&
                               req_ff.quantity < cand_ff.quantity) begin
                     state_in = lobm_pkg::S_FINISH;
                  end else begin
                     state_in = lobm_pkg::S_REMOVE;
                  end
               end
               lobm_pkg::SK_LEVEL_REM: begin
                  state_in = cont_add_ff ? lobm_pkg::S_ADD : lobm_pkg::S_FINISH;
               end
               lobm_pkg::SK_LEVEL_REST: begin
                  if (!free_found_ff || (!found_ff && level_full)) begin
                     state_in = lobm_pkg::S_PUSH;
                  end else begin
                     state_in = lobm_pkg::S_REST_WRITE;
                  end
               end
               default: state_in = lobm_pkg::S_PUSH;
            endcase
         end
         lobm_pkg::S_FILL: begin
            if (can_push) begin
               state_in = (work_qty_ff >= cand_ff.quantity) ? lobm_pkg::S_REMOVE
                                                            : lobm_pkg::S_ADD;
            end
         end
         lobm_pkg::S_REMOVE: state_in = lobm_pkg::S_SCAN;
         lobm_pkg::S_REST_WRITE: state_in = lobm_pkg::S_FINISH;
         lobm_pkg::S_PUSH: begin
            if (can_push) begin
               state_in = lobm_pkg::S_FINISH;
            end
         end
         lobm_pkg::S_FINISH: begin
            if (!hold_v_ff || out_free) begin
               state_in = lobm_pkg::S_IDLE;
            end
         end
         default: state_in = lobm_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_in        = req_ff;
      work_id_in    = work_id_ff;
      work_side_in  = work_side_ff;
      work_qty_in   = work_qty_ff;
      work_price_in = work_price_ff;
      work_owner_in = work_owner_ff;
      cont_add_in   = cont_add_ff;
      scan_kind_in  = scan_kind_ff;
      scan_idx_in   = scan_idx_ff;
      issue_done_in = issue_done_ff;
      rd_v_in       = 1'b0;
      rd_idx_in     = scan_idx_ff;
      found_in      = found_ff;
      cand_idx_in   = cand_idx_ff;
      cand_in       = cand_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      vol_in        = vol_ff;
      key_id_in     = key_id_ff;
      key_price_in  = key_price_ff;
      key_side_in   = key_side_ff;
      pend_in       = pend_ff;
      valid_in      = valid_ff;
      arrival_in    = arrival_ff;
      buy_tot_in    = buy_tot_ff;
      sell_tot_in   = sell_tot_ff;
      ram_we        = 1'b0;
      ram_waddr     = cand_idx_ff;
      ram_wdata     = cand_ff;
      push_en       = 1'b0;
      push_data     = '0;
      flush_en      = 1'b0;

      case (state_ff)
         lobm_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in        = req_payload;
               work_id_in    = req_payload.order_ref;
               work_side_in  = req_payload.side;
               work_qty_in   = req_payload.quantity;
               work_price_in = req_payload.price;
               work_owner_in = req_payload.account_ref;
               cont_add_in   = 1'b0;
            end
         end
         lobm_pkg::S_DECODE: begin
            scan_kind_in = lobm_pkg::SK_LOOKUP;
            key_id_in    = req_ff.order_ref;
            if (req_ff.operation == lobm_pkg::OP_QUERY) begin
               key_id_in    = req_ff.query_param;
               key_price_in = req_ff.query_param[31:0];
               key_side_in  = req_ff.query_kind[0];
               pend_in      = '0;
               pend_in.answer_query_id = req_ff.query_id;
               pend_in.result_kind = lobm_pkg::RK_DEPTH;
               pend_in.buy_levels  = buy_tot_ff;
               pend_in.sell_levels = sell_tot_ff;
               case (req_ff.query_kind)
                  lobm_pkg::QK_BID, lobm_pkg::QK_OFFER: scan_kind_in = lobm_pkg::SK_BEST;
                  lobm_pkg::QK_VOLUME: scan_kind_in = lobm_pkg::SK_VOLUME;
                  default: scan_kind_in = lobm_pkg::SK_LOOKUP;
               endcase
            end
         end
         lobm_pkg::S_ADD: begin
            scan_kind_in = lobm_pkg::SK_MATCH;
         end
         lobm_pkg::S_EVAL: begin
            case (scan_kind_ff)
               lobm_pkg::SK_MATCH: begin
                  scan_kind_in = lobm_pkg::SK_LEVEL_REST;
                  key_price_in = work_price_ff;
                  key_side_in  = work_side_ff;
               end
               lobm_pkg::SK_LOOKUP: begin
                  pend_in = '0;
                  pend_in.answer_query_id = req_ff.query_id;
                  pend_in.result_kind = lobm_pkg::RK_NOTFOUND;
                  if (found_ff) begin
                     pend_in.result_kind   = lobm_pkg::RK_INFO;
                     pend_in.answer_price  = cand_ff.price;
                     pend_in.answer_volume = cand_ff.quantity;
                     pend_in.answer_side   = cand_ff.side;
                  end
                  if (found_ff && req_ff.operation == lobm_pkg::OP_REDUCE &&
                      req_ff.quantity < cand_ff.quantity) begin
                     ram_we    = 1'b1;
                     ram_wdata.quantity = cand_ff.quantity - req_ff.quantity;
                  end
                  if (found_ff && req_ff.operation == lobm_pkg::OP_REPLACE) begin
                     work_id_in    = req_ff.new_order_id;
                     work_side_in  = cand_ff.side;
                     work_owner_in = cand_ff.owner;
                     work_qty_in   = req_ff.quantity;
                     work_price_in = req_ff.price;
                     cont_add_in   = 1'b1;
                  end
               end
               lobm_pkg::SK_LEVEL_REM: begin
                  if (!found_ff) begin
                     if (key_side_ff) begin
                        sell_tot_in = sell_tot_ff - 6'd1;
                     end else begin
                        buy_tot_in = buy_tot_ff - 6'd1;
                     end
                  end
               end
               lobm_pkg::SK_LEVEL_REST: begin
                  pend_in = '0;
                  pend_in.result_kind = lobm_pkg::RK_REJECT;
                  if (free_found_ff && !found_ff && !level_full) begin
                     if (work_side_ff) begin
                        sell_tot_in = sell_tot_ff + 6'd1;
                     end else begin
                        buy_tot_in = buy_tot_ff + 6'd1;
                     end
                  end
               end
               lobm_pkg::SK_VOLUME: begin
                  pend_in.result_kind   = lobm_pkg::RK_VOLUME;
                  pend_in.buy_levels    = '0;
                  pend_in.sell_levels   = '0;
                  pend_in.answer_volume = vol_ff;
               end
               default: begin
                  pend_in.result_kind  = key_side_ff ? lobm_pkg::RK_OFFER : lobm_pkg::RK_BID;
                  pend_in.buy_levels   = '0;
                  pend_in.sell_levels  = '0;
                  pend_in.answer_price = found_ff ? cand_ff.price : '0;
               end
            endcase
         end
         lobm_pkg::S_FILL: begin
            if (can_push) begin
               push_en = 1'b1;
               push_data.result_kind     = lobm_pkg::RK_EXEC;
               push_data.buyer_order_id  = work_side_ff ? cand_ff.ident : work_id_ff;
               push_data.seller_order_id = work_side_ff ? work_id_ff : cand_ff.ident;
               push_data.trade_price     = cand_ff.price;
               push_data.trade_quantity  = fill_qty;
               work_qty_in = work_qty_ff - fill_qty;
               cont_add_in = 1'b1;
               if (work_qty_ff < cand_ff.quantity) begin
                  ram_we    = 1'b1;
                  ram_wdata.quantity = cand_ff.quantity - work_qty_ff;
               end
            end
         end
         lobm_pkg::S_REMOVE: begin
            valid_in[cand_idx_ff] = 1'b0;
            scan_kind_in = lobm_pkg::SK_LEVEL_REM;
            key_price_in = cand_ff.price;
            key_side_in  = cand_ff.side;
         end
         lobm_pkg::S_REST_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = free_idx_ff;
            ram_wdata.ident    = work_id_ff;
            ram_wdata.side     = work_side_ff;
            ram_wdata.quantity = work_qty_ff;
            ram_wdata.price    = work_price_ff;
            ram_wdata.owner    = work_owner_ff;
            ram_wdata.arrival  = arrival_ff;
            valid_in[free_idx_ff] = 1'b1;
            arrival_in = arrival_ff + 32'd1;
         end
         lobm_pkg::S_PUSH: begin
            if (can_push) begin
               push_en   = 1'b1;
               push_data = pend_ff;
            end
         end
         lobm_pkg::S_FINISH: begin
            flush_en = hold_v_ff && out_free;
         end
         default: begin
         end
      endcase

      if (state_ff != lobm_pkg::S_SCAN && state_in == lobm_pkg::S_SCAN) begin
         scan_idx_in   = '0;
         issue_done_in = 1'b0;
         found_in      = 1'b0;
         free_found_in = 1'b0;
         vol_in        = '0;
      end

      if (state_ff == lobm_pkg::S_SCAN) begin
         rd_v_in   = !issue_done_ff;
         rd_idx_in = scan_idx_ff;
         if (!issue_done_ff) begin
            if (scan_idx_ff == LAST_IDX) begin
               issue_done_in = 1'b1;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         if (rd_v_ff && !valid_ff[rd_idx_ff] && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
         if (rd_vld) begin
            case (scan_kind_ff)
               lobm_pkg::SK_MATCH: begin
                  if (rd_entry.side != work_side_ff && rd_entry.owner != work_owner_ff &&
                      (work_side_ff ? rd_entry.price >= work_price_ff
                                    : rd_entry.price <= work_price_ff) &&
                      (!found_ff ||
                       (rd_entry.price != cand_ff.price &&
                        (work_side_ff ? rd_entry.price > cand_ff.price
                                      : rd_entry.price < cand_ff.price)) ||
                       (rd_entry.price == cand_ff.price && age_rd > age_cand))) begin
                     found_in    = 1'b1;
                     cand_idx_in = rd_idx_ff;
                     cand_in     = rd_entry;
                  end
               end
               lobm_pkg::SK_LOOKUP: begin
                  if (rd_entry.ident == key_id_ff && (!found_ff || age_rd < age_cand)) begin
                     found_in    = 1'b1;
                     cand_idx_in = rd_idx_ff;
                     cand_in     = rd_entry;
                  end
               end
               lobm_pkg::SK_LEVEL_REM, lobm_pkg::SK_LEVEL_REST: begin
                  if (rd_entry.price == key_price_ff && rd_entry.side == key_side_ff) begin
                     found_in = 1'b1;
                  end
               end
               lobm_pkg::SK_VOLUME: begin
                  if (rd_entry.price == key_price_ff) begin
                     vol_in = vol_sum[32] ? '1 : vol_sum[31:0];
                  end
               end
               default: begin
                  if (rd_entry.side == key_side_ff &&
                      (!found_ff || (key_side_ff ? rd_entry.price < cand_ff.price
                                                 : rd_entry.price > cand_ff.price))) begin
                     found_in = 1'b1;
                     cand_in  = rd_entry;
                  end
               end
            endcase
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      hold_v_in    = hold_v_ff;
      hold_in      = hold_ff;
      if (push_en) begin
         if (hold_v_ff) begin
            rsp_valid_in     = 1'b1;
            rsp_data_in      = hold_ff;
            rsp_data_in.last = 1'b0;
         end
         hold_v_in = 1'b1;
         hold_in   = push_data;
      end
      if (flush_en) begin
         rsp_valid_in     = 1'b1;
         rsp_data_in      = hold_ff;
         rsp_data_in.last = 1'b1;
         hold_v_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lobm_pkg::S_IDLE;
         valid_ff     <= '0;
         arrival_ff   <= '0;
         buy_tot_ff   <= '0;
         sell_tot_ff  <= '0;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_v_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         arrival_ff   <= arrival_in;
         buy_tot_ff   <= buy_tot_in;
         sell_tot_ff  <= sell_tot_in;
         hold_v_ff    <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_v_ff      <= rd_v_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      work_id_ff    <= work_id_in;
      work_side_ff  <= work_side_in;
      work_qty_ff   <= work_qty_in;
      work_price_ff <= work_price_in;
      work_owner_ff <= work_owner_in;
      cont_add_ff   <= cont_add_in;
      scan_kind_ff  <= scan_kind_in;
      scan_idx_ff   <= scan_idx_in;
      issue_done_ff <= issue_done_in;
      rd_idx_ff     <= rd_idx_in;
      found_ff      <= found_in;
      cand_idx_ff   <= cand_idx_in;
      cand_ff       <= cand_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      vol_ff        <= vol_in;
      key_id_ff     <= key_id_in;
      key_price_ff  <= key_price_in;
      key_side_ff   <= key_side_in;
      pend_ff       <= pend_in;
      hold_ff       <= hold_in;
      rsp_data_ff   <= rsp_data_in;
   end

   a_levels_bounded: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, buy_tot_ff} + {1'b0, sell_tot_ff}) <= LEVEL_CAP)
      else $error("level count exceeds the level capacity");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lobm_pkg::S_SCAN) |-> !ram_we)
      else $error("order memory written during a scan");

   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lobm_pkg::S_IDLE) |-> !hold_v_ff)
      else $error("result left behind when a new transfer can be taken");

   a_fill_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lobm_pkg::S_FILL) |-> (cand_ff.quantity != '0 && work_qty_ff != '0))
      else $error("fill with a zero quantity");

endmodule
